// File: src/modem_response_matcher_assert.svh
// Assertion macros used by the matcher of the modem response matcher RTL (mrm_matcher).
`ifndef MODEM_RESPONSE_MATCHER_ASSERT_SVH
`define MODEM_RESPONSE_MATCHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MRM_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MRM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mrm_pkg.sv
// Package with reply codes, character constants and shared types of the reply matcher.
`default_nettype none

package mrm_pkg;

    localparam int CodeWidth = 3;

    localparam logic [CodeWidth-1:0] CODE_NONE = 3'd0;
    localparam logic [CodeWidth-1:0] CODE_CMD  = 3'd1;
    localparam logic [CodeWidth-1:0] CODE_AOK  = 3'd2;
    localparam logic [CodeWidth-1:0] CODE_END  = 3'd3;
    localparam logic [CodeWidth-1:0] CODE_CONN = 3'd4;

    localparam logic [7:0] CHAR_A  = 8'h41;
    localparam logic [7:0] CHAR_C  = 8'h43;
    localparam logic [7:0] CHAR_D  = 8'h44;
    localparam logic [7:0] CHAR_E  = 8'h45;
    localparam logic [7:0] CHAR_K  = 8'h4B;
    localparam logic [7:0] CHAR_M  = 8'h4D;
    localparam logic [7:0] CHAR_N  = 8'h4E;
    localparam logic [7:0] CHAR_O  = 8'h4F;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef logic [CodeWidth-1:0] code_t;

    // Result of one item as produced by the matcher.
    typedef struct packed {
        logic  completed;
        code_t code;
    } mrm_result_t;

endpackage

`default_nettype wire

// File: src/mrm_matcher.sv
// Reply matcher: parser state, candidate and latched codes, and the per-item result logic.
`default_nettype none

`include "modem_response_matcher_assert.svh"

module mrm_matcher (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step,      // an item is processed this cycle
    input  wire logic                query,     // 1 = read and clear, 0 = parse byte
    input  wire logic [7:0]          rx_byte,
    output mrm_pkg::mrm_result_t     res
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_C    = 4'd1;
    localparam logic [3:0] ST_CM   = 4'd2;
    localparam logic [3:0] ST_A    = 4'd3;
    localparam logic [3:0] ST_AO   = 4'd4;
    localparam logic [3:0] ST_CO   = 4'd5;
    localparam logic [3:0] ST_CON  = 4'd6;
    localparam logic [3:0] ST_E    = 4'd7;
    localparam logic [3:0] ST_EN   = 4'd8;
    localparam logic [3:0] ST_WCR  = 4'd9;
    localparam logic [3:0] ST_WLF  = 4'd10;

    logic [3:0]     state_reg, state_next;
    mrm_pkg::code_t cand_reg, cand_next;
    logic           pending_reg, pending_next;
    mrm_pkg::code_t latched_reg, latched_next;

    // Byte parsing: next state, candidate update and completion.
    logic [3:0]     parse_state;
    mrm_pkg::code_t parse_cand;
    mrm_pkg::code_t parse_done;

    always_comb begin
        parse_state = ST_IDLE;
        parse_cand  = cand_reg;
        parse_done  = mrm_pkg::CODE_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                parse_cand = mrm_pkg::CODE_NONE;
                priority if (rx_byte == mrm_pkg::CHAR_C) begin
                    parse_state = ST_C;
                end else if (rx_byte == mrm_pkg::CHAR_A) begin
                    parse_state = ST_A;
                end else if (rx_byte == mrm_pkg::CHAR_E) begin
                    parse_state = ST_E;
                end else begin
                    parse_state = ST_IDLE;
                end
            end
            ST_C: begin
                priority if (rx_byte == mrm_pkg::CHAR_M) begin
                    parse_state = ST_CM;
                end else if (rx_byte == mrm_pkg::CHAR_O) begin
                    parse_state = ST_CO;
                end else begin
                    parse_state = ST_IDLE;
                end
            end
            ST_CM: begin
                if (rx_byte == mrm_pkg::CHAR_D) begin
                    parse_cand  = mrm_pkg::CODE_CMD;
                    parse_state = ST_WCR;
                end
            end
            ST_A: begin
                if (rx_byte == mrm_pkg::CHAR_O) begin
                    parse_state = ST_AO;
                end
            end
            ST_AO: begin
                if (rx_byte == mrm_pkg::CHAR_K) begin
                    parse_cand  = mrm_pkg::CODE_AOK;
                    parse_state = ST_WCR;
                end
            end
            ST_CO: begin
                if (rx_byte == mrm_pkg::CHAR_N) begin
                    parse_state = ST_CON;
                end
            end
            ST_CON: begin
                // CONN has no terminator, so it completes on the second N.
                if (rx_byte == mrm_pkg::CHAR_N) begin
                    parse_cand = mrm_pkg::CODE_CONN;
                    parse_done = mrm_pkg::CODE_CONN;
                end
            end
            ST_E: begin
                if (rx_byte == mrm_pkg::CHAR_N) begin
                    parse_state = ST_EN;
                end
            end
            ST_EN: begin
                if (rx_byte == mrm_pkg::CHAR_D) begin
                    parse_cand  = mrm_pkg::CODE_END;
                    parse_state = ST_WCR;
                end
            end
            ST_WCR: begin
                if (rx_byte == mrm_pkg::CHAR_CR) begin
                    parse_state = ST_WLF;
                end
            end
            ST_WLF: begin
                if (rx_byte == mrm_pkg::CHAR_LF) begin
                    parse_done = cand_reg;
                end
            end
            default: begin
                parse_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cand_next    = cand_reg;
        pending_next = pending_reg;
        latched_next = latched_reg;
        res.completed = 1'b0;
        res.code      = mrm_pkg::CODE_NONE;
        if (query) begin
            res.code = pending_reg ? latched_reg : mrm_pkg::CODE_NONE;
            if (step) begin
                pending_next = 1'b0;
            end
        end else begin
            res.completed = (parse_done != mrm_pkg::CODE_NONE);
            res.code      = parse_done;
            if (step) begin
                state_next = parse_state;
                cand_next  = parse_cand;
                if (parse_done != mrm_pkg::CODE_NONE) begin
                    pending_next = 1'b1;
                    latched_next = parse_done;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cand_reg    <= mrm_pkg::CODE_NONE;
            pending_reg <= 1'b0;
            latched_reg <= mrm_pkg::CODE_NONE;
        end else begin
            state_reg   <= state_next;
            cand_reg    <= cand_next;
            pending_reg <= pending_next;
            latched_reg <= latched_next;
        end
    end

    `MRM_ASSERT_NEXT(a_latch_on_complete, aclk, aresetn, step && res.completed, pending_reg && latched_reg == $past(res.code), "completed reply was not latched")
    `MRM_ASSERT_NEXT(a_query_clears, aclk, aresetn, step && query, !pending_reg, "query left the pending flag set")
    `MRM_ASSERT_NEXT(a_query_keeps_state, aclk, aresetn, step && query, $stable(state_reg) && $stable(latched_reg), "query disturbed the matcher")
    `MRM_ASSERT_IMPLY(a_state_range, aclk, aresetn, 1'b1, state_reg <= ST_WLF, "matcher in an unused state")

endmodule

`default_nettype wire

// File: src/modem_response_matcher.sv
// Top level of the modem reply matcher: input beat register, matcher and result register.
//
//   Channel  Direction  tdata                      tuser
//   s_axis   in         [7:0] rx_byte              [0] req_type
//   m_axis   out        [2:0] response_code, pad   [0] completed
//
// One beat is accepted per cycle when the result side keeps up.
// A beat passes through the input register, then the matcher logic into the result register.
// The matcher state updates as each beat advances, which allows one beat per cycle when the result side keeps up.
// Reset clears both valid flags and the matcher state; payload registers are not reset.
// A stall on m_axis backs up into the input register, then drops s_axis_tready.
`default_nettype none

module modem_response_matcher (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  wire logic       s_axis_tuser,   // [0] req_type
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [2:0] response_code, [7:3] zero
    output logic            m_axis_tuser    // [0] completed
);

    logic       in_valid_reg;
    logic       in_query_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    mrm_pkg::mrm_result_t out_res_reg;
    mrm_pkg::mrm_result_t res;

    logic out_ready;
    logic advance;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    mrm_matcher u_matcher (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .query   (in_query_reg),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_query_reg <= s_axis_tuser;
            in_byte_reg  <= s_axis_tdata;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_res_reg.code};
    assign m_axis_tuser  = out_res_reg.completed;

endmodule

`default_nettype wire
